// File: rtl/bmp24_pkg.sv
package bmp24_pkg;

  localparam logic [2:0] ST_PIXEL   = 3'd0;
  localparam logic [2:0] ST_NOT_BMP = 3'd1;
  localparam logic [2:0] ST_FORMAT  = 3'd2;
  localparam logic [2:0] ST_OFFSET  = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] DATA_OFFSET   = 32'd54;
  localparam logic [15:0] BIT_COUNT     = 16'd24;
  localparam logic [5:0]  HDR_LAST      = 6'd53;

  // one decoded result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] column;
    logic [12:0] row;
    logic        last_pixel;
  } bmp24_res_t;

  // what one input byte produced: up to two results
  typedef struct packed {
    logic       has_a;
    bmp24_res_t res_a;
    logic       has_b;
  } bmp24_entry_t;

endpackage

// File: rtl/bmp24_stream_decoder_top.sv
// a result is registered in the queue before it is offered at the output
// throughput: one byte per cycle while the queue has space; a byte causing two results is output as two items
// the set rate is held by a 3-entry queue between the header/pixel parser and the output
// reset: synchronous active-low rst_n clears parser state and empties the queue
// an end-of-file byte returns the parser to its reset state
module bmp24_stream_decoder_top
  import bmp24_pkg::*;
#(
  parameter int MAX_DIM = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [12:0] out_column,
  output logic [12:0] out_row,
  output logic        out_last_pixel,
  output logic        out_last_of_run
);

  logic         fe_valid, q_space, q_valid, q_pop;
  bmp24_entry_t fe_entry, q_entry;
  bmp24_res_t   res;

  // parser advances only when the queue can absorb a possible entry
  assign in_ready = q_space;

  bmp24_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk(clk), .rst_n(rst_n),
    .byte_valid(in_valid && in_ready),
    .data_byte(in_data_byte), .end_of_file(in_end_of_file),
    .entry_valid(fe_valid), .entry(fe_entry)
  );

  bmp24_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fe_valid), .wr_entry(fe_entry), .space(q_space),
    .rd_valid(q_valid), .rd_entry(q_entry), .rd_pop(q_pop)
  );

  bmp24_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res(res), .out_last(out_last_of_run)
  );

  assign out_status     = res.status;
  assign out_red        = res.red;
  assign out_green      = res.green;
  assign out_blue       = res.blue;
  assign out_column     = res.column;
  assign out_row        = res.row;
  assign out_last_pixel = res.last_pixel;

endmodule

// File: rtl/bmp24_front.sv
module bmp24_front
  import bmp24_pkg::*;
#(
  parameter int MAX_DIM = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_valid,
  input  logic [7:0]   data_byte,
  input  logic         end_of_file,
  output logic         entry_valid,
  output bmp24_entry_t entry
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_PIXEL  = 3'd1;
  localparam logic [2:0] PH_PAD    = 3'd2;
  localparam logic [2:0] PH_IDLE   = 3'd3;
  localparam logic [31:0] MAX_W    = 32'(MAX_DIM);

  logic [2:0]  phase_r, phase_nxt;
  logic [5:0]  hidx_r;
  logic [15:0] sig_r, planes_r, bits_r;
  logic [31:0] offs_r, width_r, height_r, comp_r, size_r;
  logic [12:0] col_r, frow_r;
  logic [1:0]  pidx_r, pad_r;
  logic [7:0]  blue_r, green_r;

  // image size product is precomputed as bytes arrive, split across cycles
  logic [31:0] pitch_r;
  logic [31:0] prod_r;
  logic        dims_ok_r;

  logic [15:0] sig_now;
  logic [31:0] offs_now;
  logic [31:0] pitch_w;
  logic        row_end, last_row, fmt_ok, adv_row;
  bmp24_res_t  res;

  assign sig_now  = (hidx_r == 6'd1) ? {data_byte, sig_r[7:0]} : sig_r;
  assign offs_now = offs_r;
  assign pitch_w  = ((width_r * 32'd3) + 32'd3) & ~32'd3;
  assign row_end  = ({19'd0, col_r} + 32'd1) >= width_r;
  assign last_row = ({19'd0, frow_r} + 32'd1) >= height_r;
  assign fmt_ok   = dims_ok_r && planes_r == 16'd1 && bits_r == BIT_COUNT &&
                    comp_r == 32'd0 && size_r == prod_r;
  assign adv_row  = last_row;

  always_comb begin
    res = '0;
    entry = '0;
    entry_valid = 1'b0;
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (hidx_r == 6'd1 && sig_now != BMP_SIGNATURE) begin
          entry.has_a = 1'b1; entry.res_a.status = ST_NOT_BMP;
          phase_nxt = PH_IDLE;
        end else if (hidx_r >= HDR_LAST) begin
          if (!fmt_ok) begin
            entry.has_a = 1'b1; entry.res_a.status = ST_FORMAT;
            phase_nxt = PH_IDLE;
          end else if (offs_now != DATA_OFFSET) begin
            entry.has_a = 1'b1; entry.res_a.status = ST_OFFSET;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_PIXEL;
          end
        end
      end
      PH_PIXEL: begin
        if (pidx_r == 2'd2) begin
          res.status = ST_PIXEL;
          res.red = data_byte; res.green = green_r; res.blue = blue_r;
          res.column = col_r;
          res.row = height_r[12:0] - 13'd1 - frow_r;
          res.last_pixel = row_end && last_row;
          entry.has_a = 1'b1; entry.res_a = res;
          if (row_end) begin
            if (width_r[1:0] != 2'd0) phase_nxt = PH_PAD;
            else phase_nxt = adv_row ? PH_IDLE : PH_PIXEL;
          end
        end
      end
      PH_PAD: begin
        if (pad_r == 2'd1) phase_nxt = adv_row ? PH_IDLE : PH_PIXEL;
      end
      default: ;
    endcase
    if (end_of_file && phase_nxt != PH_IDLE) begin
      if (entry.has_a) entry.has_b = 1'b1;
      else begin
        entry.has_a = 1'b1; entry.res_a = '0; entry.res_a.status = ST_TRUNC;
      end
    end
    entry_valid = byte_valid && entry.has_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && end_of_file)) begin
      phase_r <= PH_HEADER; hidx_r <= '0; sig_r <= '0; offs_r <= '0;
      width_r <= '0; height_r <= '0; planes_r <= '0; bits_r <= '0;
      comp_r <= '0; size_r <= '0; col_r <= '0; frow_r <= '0;
      pidx_r <= '0; pad_r <= '0; blue_r <= '0; green_r <= '0;
      pitch_r <= '0; prod_r <= '0; dims_ok_r <= 1'b0;
    end else begin
      // pitch settles after width (byte 21), product after height (byte 25)
      pitch_r <= pitch_w;
      prod_r <= pitch_r * height_r;
      dims_ok_r <= width_r >= 32'd1 && width_r <= MAX_W &&
                   height_r >= 32'd1 && height_r <= MAX_W;
      if (byte_valid) begin
        phase_r <= phase_nxt;
        case (phase_r)
          PH_HEADER: begin
            case (hidx_r)
              6'd0: sig_r[7:0] <= data_byte;
              6'd1: sig_r[15:8] <= data_byte;
              6'd10, 6'd11, 6'd12, 6'd13:
                offs_r[{hidx_r[1:0] - 2'd2, 3'd0} +: 8] <= data_byte;
              6'd18, 6'd19, 6'd20, 6'd21:
                width_r[{hidx_r[1:0] - 2'd2, 3'd0} +: 8] <= data_byte;
              6'd22, 6'd23, 6'd24, 6'd25:
                height_r[{hidx_r[1:0] - 2'd2, 3'd0} +: 8] <= data_byte;
              6'd26, 6'd27: planes_r[{hidx_r[0], 3'd0} +: 8] <= data_byte;
              6'd28, 6'd29: bits_r[{hidx_r[0], 3'd0} +: 8] <= data_byte;
              6'd30, 6'd31, 6'd32, 6'd33:
                comp_r[{hidx_r[1:0] - 2'd2, 3'd0} +: 8] <= data_byte;
              6'd34, 6'd35, 6'd36, 6'd37:
                size_r[{hidx_r[1:0] - 2'd2, 3'd0} +: 8] <= data_byte;
              default: ;
            endcase
            if (phase_nxt == PH_HEADER) hidx_r <= hidx_r + 6'd1;
          end
          PH_PIXEL: begin
            case (pidx_r)
              2'd0: begin blue_r <= data_byte; pidx_r <= 2'd1; end
              2'd1: begin green_r <= data_byte; pidx_r <= 2'd2; end
              default: begin
                pidx_r <= 2'd0;
                if (row_end) begin
                  col_r <= '0;
                  pad_r <= width_r[1:0];
                  if (width_r[1:0] == 2'd0 && !adv_row) frow_r <= frow_r + 13'd1;
                end else begin
                  col_r <= col_r + 13'd1;
                end
              end
            endcase
          end
          PH_PAD: begin
            pad_r <= pad_r - 2'd1;
            if (pad_r == 2'd1 && !adv_row) frow_r <= frow_r + 13'd1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/bmp24_queue.sv
module bmp24_queue
  import bmp24_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  input  bmp24_entry_t wr_entry,
  output logic         space,
  output logic         rd_valid,
  output bmp24_entry_t rd_entry,
  input  logic         rd_pop
);

  bmp24_entry_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign space    = cnt_r < 3'd3;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_entry;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_valid) wp_r <= wp_r + 2'd1;
      if (rd_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_valid} - {2'd0, rd_pop};
    end
  end

endmodule

// File: rtl/bmp24_back.sv
module bmp24_back
  import bmp24_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  bmp24_entry_t q_entry,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output bmp24_res_t   out_res,
  output logic         out_last
);

  // second result of an entry is always the truncation item
  logic sub_r;

  assign out_valid = q_valid;
  always_comb begin
    out_res = q_entry.res_a;
    out_last = !q_entry.has_b;
    if (sub_r) begin
      out_res = '0;
      out_res.status = ST_TRUNC;
      out_last = 1'b1;
    end
  end
  assign q_pop = q_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= 1'b0;
    else if (q_valid && out_ready) sub_r <= !out_last;
  end

endmodule

// File: test/tb_bmp24_stream_decoder_top.sv
`timescale 1ns / 100ps

// decoded pixel/status item as the block should report it
typedef struct packed {
  logic [2:0]  status;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [12:0] column;
  logic [12:0] row;
  logic        last_pixel;
  logic        last_of_run;
} bmp_result_t;

class bmp_decode_scoreboard;
  typedef enum logic [1:0] {PH_HEADER, PH_PIXEL, PH_PAD, PH_IDLE} phase_e;

  phase_e      phase;
  logic [5:0]  hdr_idx;
  logic [15:0] sig;
  logic [31:0] offset, width, height, compression, img_size;
  logic [15:0] planes, bits;
  logic [12:0] col_cnt, frow_cnt;
  logic [1:0]  px_idx, pad_left;
  logic [7:0]  held_b, held_g;

  bmp_result_t pending_pixels[$];
  int          mismatches;

  function void clear();
    phase = PH_HEADER;
    hdr_idx = 0; sig = 0; offset = 0; width = 0; height = 0;
    compression = 0; img_size = 0; planes = 0; bits = 0;
    col_cnt = 0; frow_cnt = 0; px_idx = 0; pad_left = 0;
    held_b = 0; held_g = 0;
  endfunction

  function new();
    clear();
    mismatches = 0;
  endfunction

  function void add(ref bmp_result_t q[$], input logic [2:0] st, input logic [7:0] r,
                    input logic [7:0] g, input logic [7:0] b, input logic [12:0] c,
                    input logic [12:0] rw, input logic lp);
    bmp_result_t e;
    e.status = st; e.red = r; e.green = g; e.blue = b;
    e.column = c; e.row = rw; e.last_pixel = lp; e.last_of_run = 0;
    q.push_back(e);
  endfunction

  function void advance_row();
    if ({19'd0, frow_cnt} + 32'd1 >= height) phase = PH_IDLE;
    else begin
      frow_cnt++;
      phase = PH_PIXEL;
    end
  endfunction

  function bit header_good();
    logic [31:0] pitch;
    if (width < 1 || width > 8192 || height < 1 || height > 8192) return 0;
    if (planes != 1 || bits != bmp24_pkg::BIT_COUNT || compression != 0) return 0;
    pitch = (width * 3 + 3) & ~32'd3;
    return img_size == pitch * height;
  endfunction

  // predicts what one accepted byte produces
  function void note_input(logic [7:0] b, logic eof);
    bmp_result_t q[$];
    bit row_end, last_row;
    if (phase == PH_HEADER) begin
      if (hdr_idx <= 1) sig = sig | 16'({24'd0, b} << (8 * hdr_idx));
      else if (hdr_idx >= 10 && hdr_idx <= 13) offset |= {24'd0, b} << (8 * (hdr_idx - 10));
      else if (hdr_idx >= 18 && hdr_idx <= 21) width |= {24'd0, b} << (8 * (hdr_idx - 18));
      else if (hdr_idx >= 22 && hdr_idx <= 25) height |= {24'd0, b} << (8 * (hdr_idx - 22));
      else if (hdr_idx >= 26 && hdr_idx <= 27)
        planes |= 16'({24'd0, b} << (8 * (hdr_idx - 26)));
      else if (hdr_idx >= 28 && hdr_idx <= 29)
        bits |= 16'({24'd0, b} << (8 * (hdr_idx - 28)));
      else if (hdr_idx >= 30 && hdr_idx <= 33)
        compression |= {24'd0, b} << (8 * (hdr_idx - 30));
      else if (hdr_idx >= 34 && hdr_idx <= 37)
        img_size |= {24'd0, b} << (8 * (hdr_idx - 34));
      if (hdr_idx == 1 && sig != bmp24_pkg::BMP_SIGNATURE) begin
        add(q, bmp24_pkg::ST_NOT_BMP, 0, 0, 0, 0, 0, 0);
        phase = PH_IDLE;
      end else if (hdr_idx >= bmp24_pkg::HDR_LAST) begin
        if (!header_good()) begin
          add(q, bmp24_pkg::ST_FORMAT, 0, 0, 0, 0, 0, 0);
          phase = PH_IDLE;
        end else if (offset != bmp24_pkg::DATA_OFFSET) begin
          add(q, bmp24_pkg::ST_OFFSET, 0, 0, 0, 0, 0, 0);
          phase = PH_IDLE;
        end else phase = PH_PIXEL;
      end else hdr_idx = hdr_idx + 1;
    end else if (phase == PH_PIXEL) begin
      if (px_idx == 0) begin
        held_b = b; px_idx = 1;
      end else if (px_idx == 1) begin
        held_g = b; px_idx = 2;
      end else begin
        row_end = {19'd0, col_cnt} + 32'd1 >= width;
        last_row = {19'd0, frow_cnt} + 32'd1 >= height;
        add(q, bmp24_pkg::ST_PIXEL, b, held_g, held_b, col_cnt,
            13'(height - 1 - {19'd0, frow_cnt}), row_end && last_row);
        px_idx = 0;
        if (row_end) begin
          col_cnt = 0;
          pad_left = width[1:0];
          if (pad_left != 0) phase = PH_PAD;
          else advance_row();
        end else col_cnt++;
      end
    end else if (phase == PH_PAD) begin
      pad_left = pad_left - 1;
      if (pad_left == 0) advance_row();
    end
    if (eof) begin
      if (phase != PH_IDLE) add(q, bmp24_pkg::ST_TRUNC, 0, 0, 0, 0, 0, 0);
      clear();
    end
    if (q.size() > 0) q[q.size() - 1].last_of_run = 1;
    foreach (q[i]) pending_pixels.push_back(q[i]);
  endfunction

  function void check_result(bmp_result_t got);
    bmp_result_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
      return;
    end
    want = pending_pixels.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp st=%0d rgb=%h/%h/%h c=%0d r=%0d lp=%b lr=%b",
                 want.status, want.red, want.green, want.blue, want.column, want.row,
                 want.last_pixel, want.last_of_run);
        $display("          got st=%0d rgb=%h/%h/%h c=%0d r=%0d lp=%b lr=%b",
                 got.status, got.red, got.green, got.blue, got.column, got.row,
                 got.last_pixel, got.last_of_run);
      end
    end
  endfunction
endclass

module tb_bmp24_stream_decoder_top;
  import bmp24_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_file;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_red, out_green, out_blue;
  logic [12:0] out_column, out_row;
  logic        out_last_pixel, out_last_of_run;

  bmp_decode_scoreboard pixel_board;

  // idle percentages, changed per phase by the stimulus process
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  longint      cycle_count;
  int          items_sent;
  logic [7:0]  file_buf[$];

  bmp24_stream_decoder_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_last_pixel (out_last_pixel),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stall, plus a long hold-off when asked
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 0;
      end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // output monitor: compare each accepted result
  always @(posedge clk) begin
    bmp_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status; got.red = out_red; got.green = out_green;
      got.blue = out_blue; got.column = out_column; got.row = out_row;
      got.last_pixel = out_last_pixel; got.last_of_run = out_last_of_run;
      pixel_board.check_result(got);
    end
  end

  // offer one byte, hold it until accepted, then model it
  task automatic send_byte(logic [7:0] b, logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_end_of_file <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixel_board.note_input(b, eof);
    items_sent++;
  endtask

  task automatic put_le(int pos, logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) file_buf[pos + i] = v[8 * i +: 8];
  endtask

  // build a header; sizes and fields are passed in so faults can be injected
  task automatic build_header(logic [31:0] w, logic [31:0] h, logic [15:0] planes,
                              logic [15:0] bits, logic [31:0] comp, logic [31:0] off,
                              logic [31:0] sz);
    file_buf.delete();
    for (int i = 0; i < 54; i++) file_buf.push_back($urandom_range(255));
    file_buf[0] = 8'h42;
    file_buf[1] = 8'h4D;
    put_le(10, off, 4);
    put_le(18, w, 4);
    put_le(22, h, 4);
    put_le(26, {16'd0, planes}, 2);
    put_le(28, {16'd0, bits}, 2);
    put_le(30, comp, 4);
    put_le(34, sz, 4);
  endtask

  function automatic logic [31:0] pitch_size(logic [31:0] w, logic [31:0] h);
    return ((w * 3 + 3) & ~32'd3) * h;
  endfunction

  // send file_buf, optional image bytes and trailer, eof on the final byte
  task automatic send_file(int pixel_bytes, int trailer);
    for (int i = 0; i < pixel_bytes + trailer; i++) file_buf.push_back($urandom_range(255));
    foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
  endtask

  task automatic good_file(logic [31:0] w, logic [31:0] h, int cut, int trailer);
    int n;
    build_header(w, h, 1, BIT_COUNT, 0, DATA_OFFSET, pitch_size(w, h));
    n = pitch_size(w, h);
    send_file(n - cut, trailer);
  endtask

  task automatic random_file();
    int pick;
    logic [31:0] w, h;
    pick = $urandom_range(99);
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if (pick < 65) good_file(w, h, 0, $urandom_range(0, 2));
    else if (pick < 75) good_file(w, h, $urandom_range(1, 5), 0);
    else if (pick < 80) begin
      build_header(w, h, 1, BIT_COUNT, 0, $urandom, pitch_size(w, h));
      send_file(0, $urandom_range(0, 3));
    end else if (pick < 88) begin
      build_header($urandom_range(0, 1) ? $urandom : w, $urandom_range(0, 1) ? $urandom : h,
                   $urandom_range(0, 2), $urandom_range(0, 1) ? 16'($urandom) : BIT_COUNT,
                   $urandom_range(0, 1), DATA_OFFSET, $urandom_range(0, 1) ? $urandom :
                   pitch_size(w, h));
      send_file(0, $urandom_range(0, 3));
    end else if (pick < 94) begin
      // noise with random eof flags
      repeat ($urandom_range(1, 20)) send_byte($urandom_range(255), $urandom_range(0, 7) == 0);
      send_byte($urandom_range(255), 1);
    end else begin
      build_header(w, h, 1, BIT_COUNT, 0, DATA_OFFSET, pitch_size(w, h));
      file_buf = file_buf[0:$urandom_range(0, 53)];
      send_file(0, 0);
    end
  endtask

  task automatic wait_drained();
    while (pixel_board.pending_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    pixel_board = new();
    rst_n = 0;
    in_valid = 0;
    in_data_byte = 0;
    in_end_of_file = 0;
    send_idle_pct = 27;
    recv_idle_pct = 75;
    hold_off_cycles = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: minimal and padded images, flipped rows
    good_file(1, 1, 0, 0);
    good_file(2, 2, 0, 1);
    // bad signature, both bytes
    send_byte(8'h00, 0);
    send_byte(8'hFF, 1);
    send_byte(8'h42, 0);
    send_byte(8'h4C, 1);
    // extreme dimensions rejected, max accepted but truncated after seven pixel bytes; then bad offset and bad size
    build_header(0, 1, 1, BIT_COUNT, 0, DATA_OFFSET, 0);
    send_file(0, 0);
    build_header(8193, 1, 1, BIT_COUNT, 0, DATA_OFFSET, pitch_size(8193, 1));
    send_file(0, 0);
    build_header(8192, 8192, 1, BIT_COUNT, 0, DATA_OFFSET, pitch_size(8192, 8192));
    send_file(7, 0);
    build_header(3, 1, 1, BIT_COUNT, 0, 55, pitch_size(3, 1));
    send_file(0, 0);
    build_header(1, 1, 1, BIT_COUNT, 0, DATA_OFFSET, 5);
    send_file(0, 0);
    // eof on the very first byte
    send_byte(8'h42, 1);

    // long hold-off while the sender keeps pushing
    hold_off_cycles = 300;
    good_file(4, 3, 0, 0);

    while (items_sent < 1000) begin
      if (items_sent > 400 && send_idle_pct == 27) begin
        send_idle_pct = 75; recv_idle_pct = 27;
      end else if (items_sent > 800 && send_idle_pct == 75) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_file();
    end
    in_valid <= 0;
    wait_drained();
    repeat (20) @(posedge clk);

    if (pixel_board.mismatches == 0 && pixel_board.pending_pixels.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
